// ----- sv/vgarf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vgarf_pkg
// Shared constants, port codes and types of the VGA register file shadow.
// ----------------------------------------------------------------------------
package vgarf_pkg;

	// register counts of the shadowed groups
	localparam int CRTC_COUNT      = 25;
	localparam int GRAPHICS_COUNT  = 9;
	localparam int SEQUENCER_COUNT = 5;
	localparam int ATTRIBUTE_COUNT = 21;
	localparam int MISC_COUNT      = 6;
	localparam int PALETTE_SIZE    = 768;

	// shadow memory map: palette bytes first, then the register groups
	localparam int CRTC_BASE  = PALETTE_SIZE;
	localparam int GFX_BASE   = CRTC_BASE + CRTC_COUNT;
	localparam int SEQ_BASE   = GFX_BASE + GRAPHICS_COUNT;
	localparam int ATTR_BASE  = SEQ_BASE + SEQUENCER_COUNT;
	localparam int MISC_BASE  = ATTR_BASE + ATTRIBUTE_COUNT;
	localparam int MEM_DEPTH  = MISC_BASE + MISC_COUNT;
	localparam int ADDR_W     = $clog2(MEM_DEPTH);
	localparam int DAC_W      = $clog2(PALETTE_SIZE);

	// slots of the misc/status group
	localparam int SLOT_MISC    = 0;
	localparam int SLOT_STAT0   = 1;
	localparam int SLOT_STAT1   = 2;
	localparam int SLOT_PELMASK = 3;
	localparam int SLOT_FEAT1   = 4;
	localparam int SLOT_FEAT2   = 5;

	// byte index / 3 as multiply by reciprocal, exact for indices below 768
	localparam int DIV3_MUL   = 683;
	localparam int DIV3_SHIFT = 11;

	localparam logic [7:0] PEL_DEFAULT = 8'hFF;
	localparam logic [4:0] ATTR_IDX_MASK = 5'h1F;

	// standard VGA port addresses
	localparam logic [9:0] P_CRTC_I_MONO  = 10'h3B4;
	localparam logic [9:0] P_CRTC_D_MONO  = 10'h3B5;
	localparam logic [9:0] P_STAT1_MONO   = 10'h3BA;
	localparam logic [9:0] P_ATTR_W       = 10'h3C0;
	localparam logic [9:0] P_ATTR_R       = 10'h3C1;
	localparam logic [9:0] P_MISC_W       = 10'h3C2;
	localparam logic [9:0] P_SEQ_I        = 10'h3C4;
	localparam logic [9:0] P_SEQ_D        = 10'h3C5;
	localparam logic [9:0] P_PELMASK      = 10'h3C6;
	localparam logic [9:0] P_DAC_RI       = 10'h3C7;
	localparam logic [9:0] P_DAC_WI       = 10'h3C8;
	localparam logic [9:0] P_DAC_D        = 10'h3C9;
	localparam logic [9:0] P_FEAT2        = 10'h3CA;
	localparam logic [9:0] P_MISC_R       = 10'h3CC;
	localparam logic [9:0] P_GFX_I        = 10'h3CE;
	localparam logic [9:0] P_GFX_D        = 10'h3CF;
	localparam logic [9:0] P_CRTC_I_COLOR = 10'h3D4;
	localparam logic [9:0] P_CRTC_D_COLOR = 10'h3D5;
	localparam logic [9:0] P_STAT1_COLOR  = 10'h3DA;

	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	// access decoded by the control unit for the current item
	typedef struct packed {
		logic              mem_rd;    // result comes from the shadow memory
		logic              mem_we;    // store mem_wdata at mem_addr
		logic              pel_fix;   // stored zero reads as 0xFF
		logic              fwd;       // not handled by the shadow
		logic [ADDR_W-1:0] mem_addr;
		logic [7:0]        mem_wdata;
		logic [7:0]        imm_data;  // result when no memory read is needed
	} acc_req_t;

endpackage
`default_nettype wire

// ----- sv/vga_register_file_emulation_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vga_register_file_emulation_top
// Shadow of the VGA I/O register file and DAC palette, one byte access per item.
// ----------------------------------------------------------------------------
// Usage:
//   Each item on the s_ channel is one byte read or write at a VGA port
//   (s_tuser = 0 read, 1 write). Each item yields exactly one item on the
//   m_ channel: the byte read (0 for writes) and a forwarded flag for
//   accesses the shadow does not handle (unknown port, index out of range,
//   wrong direction, or direct access mode).
//   Register groups and the 768-byte palette share one single-port RAM with
//   registered read data. Writes, index reads and forwarded accesses produce
//   a result in the cycle after acceptance and can follow every cycle while
//   the receiver keeps up; reads of shadow data hold off new items in ST_READ
//   until the registered RAM data is there. After reset the RAM is swept to
//   zero, one entry per cycle, with s_tready low meanwhile. cfg_we/cfg_wdata
//   set direct access mode at any time and are meant to change only idle.
//   A stalled receiver holds the result in the output register; a new item
//   is taken only once that register is free or being emptied.
// ----------------------------------------------------------------------------
module vga_register_file_emulation_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,   // direct_access
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,     // [9:0] io_port, [17:10] write_data, rest zero
	input  wire logic [0:0]  s_tuser,     // [0] req_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,     // [7:0] read_data
	output logic [0:0]       m_tuser      // [0] forwarded
);

	localparam int AW = vgarf_pkg::ADDR_W;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ
	} state_t;

	state_t               state_q;
	logic [AW-1:0]        clr_cnt_q;
	logic                 direct_q;
	logic                 out_valid_q;
	logic [7:0]           out_data_q;
	logic                 out_fwd_q;
	logic                 pel_fix_s1;

	logic                 acc;
	vgarf_pkg::acc_req_t  req;
	logic                 ram_we;
	logic [AW-1:0]        ram_addr;
	logic [7:0]           ram_wdata;
	logic [7:0]           ram_rdata;

	// take an item only when idle and the output register can hold its result
	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign acc      = s_tvalid && s_tready;

	vgarf_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.acc           (acc),
		.direct_access (direct_q),
		.req_type      (s_tuser[0]),
		.io_port       (s_tdata[9:0]),
		.write_data    (s_tdata[17:10]),
		.req           (req)
	);

	// the sweep owns the RAM port until it finishes
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_addr  = clr_cnt_q;
			ram_wdata = '0;
		end else begin
			ram_we    = acc && req.mem_we;
			ram_addr  = req.mem_addr;
			ram_wdata = req.mem_wdata;
		end
	end

	vgarf_ram #(
		.WIDTH (8),
		.DEPTH (vgarf_pkg::MEM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direct_q <= 1'b0;
		end else if (cfg_we) begin
			direct_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_fwd_q   <= 1'b0;
			pel_fix_s1  <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(vgarf_pkg::MEM_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc && !req.mem_rd) begin
						out_valid_q <= 1'b1;
						out_data_q  <= req.imm_data;
						out_fwd_q   <= req.fwd;
					end else begin
						// drop the held result once the receiver takes it
						if (m_tready) begin
							out_valid_q <= 1'b0;
						end
						if (acc) begin
							// read the RAM; its registered data is taken in ST_READ
							pel_fix_s1 <= req.pel_fix;
							state_q    <= ST_READ;
						end
					end
				end
				ST_READ: begin
					out_valid_q <= 1'b1;
					out_fwd_q   <= 1'b0;
					out_data_q  <= (pel_fix_s1 && ram_rdata == 8'd0)
						? vgarf_pkg::PEL_DEFAULT : ram_rdata;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_fwd_q;

endmodule
`default_nettype wire

// ----- sv/vgarf_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vgarf_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module vgarf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- sv/vgarf_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vgarf_ctrl
// Port decode and index registers; turns one access into a memory request.
// ----------------------------------------------------------------------------
module vgarf_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                acc,
	input  wire logic                direct_access,
	input  wire logic                req_type,
	input  wire logic [9:0]          io_port,
	input  wire logic [7:0]          write_data,
	output vgarf_pkg::acc_req_t      req
);

	localparam int AW = vgarf_pkg::ADDR_W;
	localparam int DW = vgarf_pkg::DAC_W;

	logic [7:0]    crtc_idx_q, gfx_idx_q, seq_idx_q;
	logic [4:0]    attr_idx_q;
	logic          attr_ff_q;
	logic [DW-1:0] dac_w_q, dac_r_q;

	logic [7:0]    crtc_idx_d, gfx_idx_d, seq_idx_d;
	logic [4:0]    attr_idx_d;
	logic          attr_ff_d;
	logic [DW-1:0] dac_w_d, dac_r_d;

	logic          crtc_ok, gfx_ok, seq_ok, attr_ok;
	logic [DW+1:0] val_x3;
	logic [DW-1:0] val_idx;

	function automatic logic [DW-1:0] dac_bump(input logic [DW-1:0] idx);
		logic [DW:0] nxt;
		nxt = {1'b0, idx} + (DW+1)'(1);
		return (nxt >= (DW+1)'(vgarf_pkg::PALETTE_SIZE)) ? '0 : nxt[DW-1:0];
	endfunction

	function automatic logic [7:0] div3(input logic [DW-1:0] x);
		logic [DW+10:0] prod;
		prod = (DW+11)'(x) * (DW+11)'(vgarf_pkg::DIV3_MUL);
		return prod[vgarf_pkg::DIV3_SHIFT +: 8];
	endfunction

	function automatic logic [AW-1:0] slot(input int s);
		return AW'(vgarf_pkg::MISC_BASE + s);
	endfunction

	assign crtc_ok = 9'(crtc_idx_q) < 9'(vgarf_pkg::CRTC_COUNT);
	assign gfx_ok  = 9'(gfx_idx_q) < 9'(vgarf_pkg::GRAPHICS_COUNT);
	assign seq_ok  = 9'(seq_idx_q) < 9'(vgarf_pkg::SEQUENCER_COUNT);
	assign attr_ok = 6'(attr_idx_q) < 6'(vgarf_pkg::ATTRIBUTE_COUNT);

	// colour index times 3, folded once into the palette range
	assign val_x3  = (DW+2)'({write_data, 1'b0}) + (DW+2)'(write_data);
	assign val_idx = (val_x3 >= (DW+2)'(vgarf_pkg::PALETTE_SIZE))
		? DW'(val_x3 - (DW+2)'(vgarf_pkg::PALETTE_SIZE)) : DW'(val_x3);

	always_comb begin
		crtc_idx_d = crtc_idx_q;
		gfx_idx_d  = gfx_idx_q;
		seq_idx_d  = seq_idx_q;
		attr_idx_d = attr_idx_q;
		attr_ff_d  = attr_ff_q;
		dac_w_d    = dac_w_q;
		dac_r_d    = dac_r_q;
		req        = '0;
		req.mem_wdata = write_data;
		if (direct_access) begin
			req.fwd = 1'b1;
		end else if (req_type == vgarf_pkg::REQ_WRITE) begin
			case (io_port)
				vgarf_pkg::P_CRTC_I_MONO, vgarf_pkg::P_CRTC_I_COLOR: begin
					crtc_idx_d = write_data;
				end
				vgarf_pkg::P_CRTC_D_MONO, vgarf_pkg::P_CRTC_D_COLOR: begin
					req.fwd      = !crtc_ok;
					req.mem_we   = crtc_ok;
					req.mem_addr = AW'(vgarf_pkg::CRTC_BASE) + AW'(crtc_idx_q);
				end
				vgarf_pkg::P_GFX_I: begin
					gfx_idx_d = write_data;
				end
				vgarf_pkg::P_GFX_D: begin
					req.fwd      = !gfx_ok;
					req.mem_we   = gfx_ok;
					req.mem_addr = AW'(vgarf_pkg::GFX_BASE) + AW'(gfx_idx_q);
				end
				vgarf_pkg::P_SEQ_I: begin
					seq_idx_d = write_data;
				end
				vgarf_pkg::P_SEQ_D: begin
					req.fwd      = !seq_ok;
					req.mem_we   = seq_ok;
					req.mem_addr = AW'(vgarf_pkg::SEQ_BASE) + AW'(seq_idx_q);
				end
				vgarf_pkg::P_ATTR_W: begin
					if (attr_ff_q) begin
						attr_idx_d = write_data[4:0] & vgarf_pkg::ATTR_IDX_MASK;
						attr_ff_d  = 1'b0;
					end else begin
						attr_ff_d    = 1'b1;
						req.fwd      = !attr_ok;
						req.mem_we   = attr_ok;
						req.mem_addr = AW'(vgarf_pkg::ATTR_BASE) + AW'(attr_idx_q);
					end
				end
				vgarf_pkg::P_MISC_W: begin
					req.mem_we   = 1'b1;
					req.mem_addr = slot(vgarf_pkg::SLOT_MISC);
				end
				vgarf_pkg::P_DAC_WI: begin
					dac_w_d = val_idx;
				end
				vgarf_pkg::P_DAC_RI: begin
					dac_r_d = val_idx;
				end
				vgarf_pkg::P_DAC_D: begin
					req.mem_we   = 1'b1;
					req.mem_addr = AW'(dac_w_q);
					dac_w_d      = dac_bump(dac_w_q);
				end
				vgarf_pkg::P_PELMASK: begin
					req.mem_we   = 1'b1;
					req.mem_addr = slot(vgarf_pkg::SLOT_PELMASK);
				end
				vgarf_pkg::P_MISC_R: begin
					req.mem_we   = 1'b1;
					req.mem_addr = slot(vgarf_pkg::SLOT_FEAT1);
				end
				vgarf_pkg::P_FEAT2: begin
					req.mem_we   = 1'b1;
					req.mem_addr = slot(vgarf_pkg::SLOT_FEAT2);
				end
				default: begin
					req.fwd = 1'b1;
				end
			endcase
		end else begin
			case (io_port)
				vgarf_pkg::P_CRTC_I_MONO, vgarf_pkg::P_CRTC_I_COLOR: begin
					req.imm_data = crtc_idx_q;
				end
				vgarf_pkg::P_CRTC_D_MONO, vgarf_pkg::P_CRTC_D_COLOR: begin
					req.fwd      = !crtc_ok;
					req.mem_rd   = crtc_ok;
					req.mem_addr = AW'(vgarf_pkg::CRTC_BASE) + AW'(crtc_idx_q);
				end
				vgarf_pkg::P_GFX_I: begin
					req.imm_data = gfx_idx_q;
				end
				vgarf_pkg::P_GFX_D: begin
					req.fwd      = !gfx_ok;
					req.mem_rd   = gfx_ok;
					req.mem_addr = AW'(vgarf_pkg::GFX_BASE) + AW'(gfx_idx_q);
				end
				vgarf_pkg::P_SEQ_I: begin
					req.imm_data = seq_idx_q;
				end
				vgarf_pkg::P_SEQ_D: begin
					req.fwd      = !seq_ok;
					req.mem_rd   = seq_ok;
					req.mem_addr = AW'(vgarf_pkg::SEQ_BASE) + AW'(seq_idx_q);
				end
				vgarf_pkg::P_ATTR_W: begin
					req.imm_data = 8'(attr_idx_q);
				end
				vgarf_pkg::P_ATTR_R: begin
					req.fwd      = !attr_ok;
					req.mem_rd   = attr_ok;
					req.mem_addr = AW'(vgarf_pkg::ATTR_BASE) + AW'(attr_idx_q);
				end
				vgarf_pkg::P_STAT1_MONO, vgarf_pkg::P_STAT1_COLOR: begin
					attr_ff_d    = 1'b1;
					req.mem_rd   = 1'b1;
					req.mem_addr = slot(vgarf_pkg::SLOT_STAT1);
				end
				vgarf_pkg::P_MISC_R: begin
					req.mem_rd   = 1'b1;
					req.mem_addr = slot(vgarf_pkg::SLOT_MISC);
				end
				vgarf_pkg::P_MISC_W: begin
					req.mem_rd   = 1'b1;
					req.mem_addr = slot(vgarf_pkg::SLOT_STAT0);
				end
				vgarf_pkg::P_DAC_WI: begin
					req.imm_data = div3(dac_w_q);
				end
				vgarf_pkg::P_DAC_RI: begin
					req.imm_data = div3(dac_r_q);
				end
				vgarf_pkg::P_DAC_D: begin
					req.mem_rd   = 1'b1;
					req.mem_addr = AW'(dac_r_q);
					dac_r_d      = dac_bump(dac_r_q);
				end
				vgarf_pkg::P_PELMASK: begin
					req.mem_rd   = 1'b1;
					req.pel_fix  = 1'b1;
					req.mem_addr = slot(vgarf_pkg::SLOT_PELMASK);
				end
				default: begin
					req.fwd = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crtc_idx_q <= '0;
			gfx_idx_q  <= '0;
			seq_idx_q  <= '0;
			attr_idx_q <= '0;
			attr_ff_q  <= 1'b0;
			dac_w_q    <= '0;
			dac_r_q    <= '0;
		end else if (acc) begin
			crtc_idx_q <= crtc_idx_d;
			gfx_idx_q  <= gfx_idx_d;
			seq_idx_q  <= seq_idx_d;
			attr_idx_q <= attr_idx_d;
			attr_ff_q  <= attr_ff_d;
			dac_w_q    <= dac_w_d;
			dac_r_q    <= dac_r_d;
		end
	end

endmodule
`default_nettype wire
